// ===== rtl/core/pisa_pkg.sv =====
// Shared types, field widths and constants for the polyphase sample addressing block.
// No dependencies; imported by pisa_pipe and polyphase_interp_sample_addr_top.
package pisa_pkg;

    // Field widths
    localparam int D_W     = 16;   // fine delay
    localparam int VEC_W   = 8;    // vector index
    localparam int CHAN_W  = 8;    // channel index / tag
    localparam int ADDR_W  = 20;   // fetch address
    localparam int CNT_W   = 7;    // fetch count
    localparam int PHASE_W = 4;    // tap phase
    localparam int F_W     = 5;    // upsample factor register
    localparam int LREG_W  = 13;   // record length register
    localparam int T_W     = 7;    // filter taps register

    // Factor limits
    localparam logic [F_W-1:0] F_MIN = 5'd1;
    localparam logic [F_W-1:0] F_MAX = 5'd16;

    // Reciprocal divide: q = (x * ceil(2^RECIP_SH / f)) >> RECIP_SH, exact for x < 2^16
    localparam int RECIP_SH = 20;
    localparam int RECIP_W  = 21;

    // Vector index reduction uses a 2^VDIV_SH reciprocal
    localparam int VDIV_SH  = 16;

    // Derived filter geometry widths
    localparam int FLEN_W   = 8;   // (taps / f + 1) * f <= 143
    localparam int HALF_W   = 7;

    // Configuration register map
    localparam int              CFG_AW      = 4;
    localparam int              CFG_DW      = 32;
    localparam logic [1:0]      REG_FACTOR  = 2'd0;
    localparam logic [1:0]      REG_RECORD  = 2'd1;
    localparam logic [1:0]      REG_TAPS    = 2'd2;

    localparam logic [F_W-1:0]    FACTOR_RST = 5'd4;
    localparam logic [LREG_W-1:0] RECORD_RST = 13'd4096;
    localparam logic [T_W-1:0]    TAPS_RST   = 7'd31;

    typedef struct packed {
        logic [F_W-1:0]    factor;
        logic [LREG_W-1:0] record_len;
        logic [T_W-1:0]    taps;
    } t_cfg;

    // ceil(2^20 / f) for the legal factors
    function automatic logic [RECIP_W-1:0] recip_of(input logic [F_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            5'd2:    r = 21'd524288;
            5'd3:    r = 21'd349526;
            5'd4:    r = 21'd262144;
            5'd5:    r = 21'd209716;
            5'd6:    r = 21'd174763;
            5'd7:    r = 21'd149797;
            5'd8:    r = 21'd131072;
            5'd9:    r = 21'd116509;
            5'd10:   r = 21'd104858;
            5'd11:   r = 21'd95326;
            5'd12:   r = 21'd87382;
            5'd13:   r = 21'd80660;
            5'd14:   r = 21'd74899;
            5'd15:   r = 21'd69906;
            5'd16:   r = 21'd65536;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/pisa_pipe.sv =====
// Five-stage datapath: coarse/fine split of the delay, edge guard tests, fetch span and address.
// Depends on pisa_pkg; configuration arrives as pisa_pkg::t_cfg from the top level.
module pisa_pipe #(
    parameter int MAX_RECORD  = 4096,
    parameter int MAX_VECTORS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pisa_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pisa_pkg::D_W-1:0]     i_fine_delay,
    input  logic [pisa_pkg::VEC_W-1:0]   i_vector_index,
    input  logic [pisa_pkg::CHAN_W-1:0]  i_channel_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pisa_pkg::CHAN_W-1:0]  o_channel_tag,
    output logic [pisa_pkg::ADDR_W-1:0]  o_fetch_address,
    output logic [pisa_pkg::CNT_W-1:0]   o_fetch_count,
    output logic [pisa_pkg::PHASE_W-1:0] o_tap_phase,
    output logic                         o_needs_interp
);
    import pisa_pkg::*;

    localparam int LEN_W  = $clog2(MAX_RECORD + 1);
    localparam int LF_W   = LEN_W + F_W;
    localparam int IDX_W  = D_W + 1;
    localparam int BASE_W = VEC_W + LEN_W;
    localparam int VR     = ((1 << VDIV_SH) + MAX_VECTORS - 1) / MAX_VECTORS;
    localparam int VP_W   = VEC_W + VDIV_SH + 1;
    localparam int MV_W   = $clog2(MAX_VECTORS + 1);
    localparam int MOD_W  = 4;

    // ---------------- configuration derived values ----------------
    logic [F_W-1:0]     w_f_eff;
    logic [LEN_W-1:0]   w_len_eff;
    logic [RECIP_W-1:0] w_recip;
    logic [T_W+RECIP_W-1:0] w_prod_a, w_prod_ch;
    logic [T_W-1:0]     w_ch_num;

    logic [F_W-1:0]     r_cf;
    logic [LEN_W-1:0]   r_clen;
    logic [RECIP_W-1:0] r_crecip;
    logic [T_W-1:0]     r_ctaps, r_ca, r_cch, r_cb;
    logic [LF_W-1:0]    r_clenf;
    logic [HALF_W-1:0]  r_chalf;

    logic [T_W+F_W-1:0]   w_af;
    logic [T_W+F_W+1:0]   w_flen;

    always_comb begin
        if (i_cfg.factor < F_MIN) begin
            w_f_eff = F_MIN;
        end else if (i_cfg.factor > F_MAX) begin
            w_f_eff = F_MAX;
        end else begin
            w_f_eff = i_cfg.factor;
        end
        if (i_cfg.record_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (32'(i_cfg.record_len) > 32'(MAX_RECORD)) begin
            w_len_eff = LEN_W'(MAX_RECORD);
        end else begin
            w_len_eff = LEN_W'(i_cfg.record_len);
        end
    end

    assign w_recip   = recip_of(w_f_eff);
    assign w_ch_num  = T_W'(i_cfg.taps >> 1) + T_W'(w_f_eff) - T_W'(1);
    assign w_prod_a  = (T_W+RECIP_W)'(i_cfg.taps) * (T_W+RECIP_W)'(w_recip);
    assign w_prod_ch = (T_W+RECIP_W)'(w_ch_num) * (T_W+RECIP_W)'(w_recip);

    // second derived step: taps % f and the edge guard
    assign w_af   = (T_W+F_W)'(r_ca) * (T_W+F_W)'(r_cf);
    assign w_flen = (T_W+F_W+2)'((T_W+1)'(r_ca) + (T_W+1)'(1)) * (T_W+F_W+2)'(r_cf);

    always_ff @(posedge i_clk) begin
        r_cf     <= w_f_eff;
        r_clen   <= w_len_eff;
        r_crecip <= w_recip;
        r_ctaps  <= i_cfg.taps;
        r_ca     <= w_prod_a[RECIP_SH +: T_W];
        r_cch    <= w_prod_ch[RECIP_SH +: T_W];
        r_clenf  <= LF_W'(w_len_eff) * LF_W'(w_f_eff);
        r_cb     <= r_ctaps - w_af[T_W-1:0];
        r_chalf  <= w_flen[FLEN_W-1:1];
    end

    // ---------------- stage handshake ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    assign w_en5   = !r_v5 || i_ready;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // ---------------- stage 1: capture, vector index reduction ----------------
    logic [VP_W-1:0]       w_vprod;
    logic [VEC_W-1:0]      w_vquot;
    logic [VEC_W+MV_W-1:0] w_vback;
    logic [VEC_W-1:0]      w_vrem;

    assign w_vprod = VP_W'(i_vector_index) * VP_W'(VR);
    assign w_vquot = w_vprod[VDIV_SH +: VEC_W];
    assign w_vback = (VEC_W+MV_W)'(w_vquot) * (VEC_W+MV_W)'(MAX_VECTORS);
    assign w_vrem  = i_vector_index - w_vback[VEC_W-1:0];

    logic [D_W-1:0]    r_s1_d;
    logic [VEC_W-1:0]  r_s1_vec;
    logic [CHAN_W-1:0] r_s1_chan;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_d    <= i_fine_delay;
            r_s1_vec  <= w_vrem;
            r_s1_chan <= i_channel_index;
        end
    end

    // ---------------- stage 2: coarse index and record base ----------------
    logic [D_W+RECIP_W-1:0] w_qprod;
    logic [BASE_W-1:0]      w_base;

    assign w_qprod = (D_W+RECIP_W)'(r_s1_d) * (D_W+RECIP_W)'(r_crecip);
    assign w_base  = BASE_W'(r_s1_vec) * BASE_W'(r_clen);

    logic [D_W-1:0]    r_s2_d, r_s2_q;
    logic [ADDR_W-1:0] r_s2_base;
    logic [CHAN_W-1:0] r_s2_chan;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_d    <= r_s1_d;
            r_s2_q    <= w_qprod[RECIP_SH +: D_W];
            r_s2_base <= ADDR_W'(w_base);
            r_s2_chan <= r_s1_chan;
        end
    end

    // ---------------- stage 3: fine remainder and phase offset ----------------
    logic [D_W+F_W-1:0] w_qf;
    logic [D_W-1:0]     w_mod;

    assign w_qf  = (D_W+F_W)'(r_s2_q) * (D_W+F_W)'(r_cf);
    assign w_mod = r_s2_d - w_qf[D_W-1:0];

    logic [D_W-1:0]    r_s3_d, r_s3_q;
    logic [MOD_W-1:0]  r_s3_mod;
    logic [F_W-1:0]    r_s3_off;
    logic [ADDR_W-1:0] r_s3_base;
    logic [CHAN_W-1:0] r_s3_chan;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_d    <= r_s2_d;
            r_s3_q    <= r_s2_q;
            r_s3_mod  <= w_mod[MOD_W-1:0];
            r_s3_off  <= r_cf - F_W'(w_mod[MOD_W-1:0]);
            r_s3_base <= r_s2_base;
            r_s3_chan <= r_s2_chan;
        end
    end

    // ---------------- stage 4: path decision and fetch span ----------------
    logic             w_direct, w_past, w_over;
    logic [IDX_W-1:0] w_start, w_fallback;
    logic [T_W:0]     w_n;

    logic [IDX_W-1:0]   n_s4_idx;
    logic               n_s4_zero;
    logic [CNT_W-1:0]   n_s4_count;
    logic [PHASE_W-1:0] n_s4_phase;
    logic               n_s4_interp;

    assign w_direct = (r_s3_mod == '0)
                   || (32'(r_s3_d) < 32'(r_chalf))
                   || (32'(r_s3_d) + 32'(r_chalf) > 32'(r_clenf));
    assign w_past   = 32'(r_s3_q) >= 32'(r_clen);
    assign w_start  = IDX_W'(r_s3_q) + IDX_W'(1) - IDX_W'(r_cch);
    // samples = taps/f, plus one more when taps%f exceeds the phase offset
    assign w_n      = (T_W+1)'(r_ca) + (T_W+1)'(r_cb > T_W'(r_s3_off));
    assign w_over   = 32'(w_start) + 32'(w_n) >= 32'(r_clen);
    assign w_fallback = (r_s3_q == '0) ? '0 : IDX_W'(r_s3_q) - IDX_W'(1);

    always_comb begin
        n_s4_idx    = w_start;
        n_s4_zero   = 1'b0;
        n_s4_count  = CNT_W'(1);
        n_s4_phase  = '0;
        n_s4_interp = 1'b0;
        if (w_direct) begin
            // past the record: address collapses to zero
            n_s4_idx  = IDX_W'(r_s3_q);
            n_s4_zero = w_past;
        end else if (w_over) begin
            n_s4_idx  = w_fallback;
        end else begin
            n_s4_count  = CNT_W'(w_n);
            n_s4_phase  = r_s3_off[PHASE_W-1:0];
            n_s4_interp = 1'b1;
        end
    end

    logic [IDX_W-1:0]   r_s4_idx;
    logic               r_s4_zero;
    logic [CNT_W-1:0]   r_s4_count;
    logic [PHASE_W-1:0] r_s4_phase;
    logic               r_s4_interp;
    logic [ADDR_W-1:0]  r_s4_base;
    logic [CHAN_W-1:0]  r_s4_chan;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4_idx    <= n_s4_idx;
            r_s4_zero   <= n_s4_zero;
            r_s4_count  <= n_s4_count;
            r_s4_phase  <= n_s4_phase;
            r_s4_interp <= n_s4_interp;
            r_s4_base   <= r_s3_base;
            r_s4_chan   <= r_s3_chan;
        end
    end

    // ---------------- stage 5: address add, output register ----------------
    logic [ADDR_W-1:0]  r_s5_addr;
    logic [CNT_W-1:0]   r_s5_count;
    logic [PHASE_W-1:0] r_s5_phase;
    logic               r_s5_interp;
    logic [CHAN_W-1:0]  r_s5_chan;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_s5_addr   <= r_s4_zero ? '0 : r_s4_base + ADDR_W'(r_s4_idx);
            r_s5_count  <= r_s4_count;
            r_s5_phase  <= r_s4_phase;
            r_s5_interp <= r_s4_interp;
            r_s5_chan   <= r_s4_chan;
        end
    end

    assign o_channel_tag   = r_s5_chan;
    assign o_fetch_address = r_s5_addr;
    assign o_fetch_count   = r_s5_count;
    assign o_tap_phase     = r_s5_phase;
    assign o_needs_interp  = r_s5_interp;

    // ---------------- assertions ----------------
    a_direct_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !r_s5_interp) |-> (r_s5_count == CNT_W'(1) && r_s5_phase == '0))
        else $error("direct result without unit count and zero phase");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted transfer did not enter stage one");

    a_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !w_en5 && r_v5) |=> (r_v4 && $stable(r_s4_idx) && $stable(r_s4_chan)))
        else $error("stalled stage four item changed or vanished");

    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready) |-> !o_ready)
        else $error("full pipeline still accepting while output stalled");

endmodule

// ===== rtl/core/polyphase_interp_sample_addr_top.sv =====
// Top level of the polyphase interpolation sample addressing block: APB register file
// and the pisa_pipe datapath. Depends on pisa_pkg and pisa_pipe.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one descriptor per transfer: fine delay in
//   upsampled units, vector (scan line) index and channel index. The output channel
//   (o_valid / i_ready) returns exactly one fetch descriptor per input transfer, in order:
//   channel tag, fetch address, fetch count, tap phase and the interpolate flag.
//   Pipeline: five register stages (capture and vector index reduction, two multiplies
//   for the coarse/fine split, the guard and span decision, then the address add into
//   the output register).
//   Throughput: one transfer per cycle, sustained while the receiver does not stall.
//   Receiver stall: a full stage holds while the stage after it cannot advance; the input
//   stops taking transfers only when all five stages hold data. Nothing is dropped or repeated.
//   Reset (i_rst_n low, synchronous): all stages empty, registers return to factor 4,
//   record length 4096, 31 taps.
//   Registers: factor at 0x0, record length at 0x4, filter taps at 0x8. Write them only
//   while no transfers are in flight; derived filter geometry is registered from the derived values.
module polyphase_interp_sample_addr_top #(
    parameter int MAX_RECORD  = 4096,
    parameter int MAX_VECTORS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pisa_pkg::CFG_AW-1:0]  paddr,
    input  logic [pisa_pkg::CFG_DW-1:0]  pwdata,
    output logic [pisa_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pisa_pkg::D_W-1:0]     i_fine_delay,
    input  logic [pisa_pkg::VEC_W-1:0]   i_vector_index,
    input  logic [pisa_pkg::CHAN_W-1:0]  i_channel_index,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pisa_pkg::CHAN_W-1:0]  o_channel_tag,
    output logic [pisa_pkg::ADDR_W-1:0]  o_fetch_address,
    output logic [pisa_pkg::CNT_W-1:0]   o_fetch_count,
    output logic [pisa_pkg::PHASE_W-1:0] o_tap_phase,
    output logic                         o_needs_interp
);
    import pisa_pkg::*;

    logic [F_W-1:0]    r_factor;
    logic [LREG_W-1:0] r_record;
    logic [T_W-1:0]    r_taps;
    logic              w_wr;
    logic [1:0]        w_reg;
    t_cfg              w_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RST;
            r_record <= RECORD_RST;
            r_taps   <= TAPS_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_FACTOR: r_factor <= pwdata[F_W-1:0];
                REG_RECORD: r_record <= pwdata[LREG_W-1:0];
                REG_TAPS:   r_taps   <= pwdata[T_W-1:0];
                default: ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_FACTOR: prdata = CFG_DW'(r_factor);
            REG_RECORD: prdata = CFG_DW'(r_record);
            REG_TAPS:   prdata = CFG_DW'(r_taps);
            default:    prdata = '0;
        endcase
    end

    assign w_cfg.factor     = r_factor;
    assign w_cfg.record_len = r_record;
    assign w_cfg.taps       = r_taps;

    pisa_pipe #(
        .MAX_RECORD  (MAX_RECORD),
        .MAX_VECTORS (MAX_VECTORS)
    ) u_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_fine_delay    (i_fine_delay),
        .i_vector_index  (i_vector_index),
        .i_channel_index (i_channel_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_channel_tag   (o_channel_tag),
        .o_fetch_address (o_fetch_address),
        .o_fetch_count   (o_fetch_count),
        .o_tap_phase     (o_tap_phase),
        .o_needs_interp  (o_needs_interp)
    );

endmodule
